// File: rtl/upe_pkg.sv
// Shared types, constants and character helpers for the URI percent encoder.
// No dependencies; every rtl file refers to it by scoped names.
package upe_pkg;

  // Range restriction on the first continuation byte after a lead byte
  typedef enum logic [2:0] {
    RULE_ANY   = 3'd0,  // 80..BF
    RULE_A0_BF = 3'd1,  // after E0
    RULE_80_9F = 3'd2,  // after ED
    RULE_90_BF = 3'd3,  // after F0
    RULE_80_8F = 3'd4   // after F4
  } rule_t;

  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  // 'a' - 10, so that nibble 10 maps to 'a'
  localparam logic [7:0] CHAR_HEX_AF  = 8'h57;
  localparam logic [7:0] PRINT_LO     = 8'd32;
  localparam logic [7:0] PRINT_HI     = 8'd126;

  // One encoded request: up to three characters and its flags
  typedef struct packed {
    logic [7:0] char0;
    logic [7:0] char1;
    logic [7:0] char2;
    logic       escaped;  // three characters, else only char0
    logic       last;     // final byte of the string
    logic       bad;      // UTF-8 fault seen in this string so far
  } enc_rec_t;

  // Lowercase hex digit of a nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'd0, nib};
    return (nib < 4'd10) ? (CHAR_ZERO + wide) : (CHAR_HEX_AF + wide);
  endfunction

  // Unreserved characters: alphanumerics and - _ . ! ~ * ' ( )
  function automatic logic comp_allowed(input logic [7:0] b);
    logic ok;
    ok = 1'b0;
    case (b) inside
      [8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]: ok = 1'b1;
      8'h2d, 8'h5f, 8'h2e, 8'h21, 8'h7e, 8'h2a, 8'h27, 8'h28, 8'h29: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // Full URI set: unreserved plus reserved ; , / ? : @ & = + $ #
  function automatic logic full_allowed(input logic [7:0] b);
    logic ok;
    ok = comp_allowed(b);
    case (b) inside
      8'h3b, 8'h2c, 8'h2f, 8'h3f, 8'h3a, 8'h40, 8'h26, 8'h3d, 8'h2b, 8'h24, 8'h23:
        ok = 1'b1;
      default: ;
    endcase
    return ok;
  endfunction

endpackage

// File: rtl/upe_utf8_track.sv
// Strict UTF-8 checker: pending continuation count, second byte rule and the
// sticky fault flag of the current string. Depends on upe_pkg.
module upe_utf8_track (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] byte_in,
  input  logic       last_in,
  output logic       bad
);

  logic [1:0]     pend_r, pend_nxt, pend_upd;
  upe_pkg::rule_t rule_r, rule_nxt, rule_upd;
  logic           fail_r, fail_nxt, fail_upd;
  logic           rule_ok;

  // Check the byte against the rule left by the lead byte
  always_comb begin
    unique case (rule_r)
      upe_pkg::RULE_A0_BF: rule_ok = (byte_in >= 8'ha0);
      upe_pkg::RULE_80_9F: rule_ok = (byte_in <= 8'h9f);
      upe_pkg::RULE_90_BF: rule_ok = (byte_in >= 8'h90);
      upe_pkg::RULE_80_8F: rule_ok = (byte_in <= 8'h8f);
      default:             rule_ok = 1'b1;
    endcase
  end

  // Advance the decoder by one byte
  always_comb begin
    pend_upd = pend_r;
    rule_upd = rule_r;
    fail_upd = fail_r;
    if (pend_r != 2'd0) begin
      if (byte_in >= 8'h80 && byte_in <= 8'hbf && rule_ok) begin
        pend_upd = pend_r - 2'd1;
      end else begin
        fail_upd = 1'b1;
        pend_upd = 2'd0;
      end
      rule_upd = upe_pkg::RULE_ANY;
    end else if (byte_in >= 8'hc2 && byte_in <= 8'hdf) begin
      pend_upd = 2'd1;
      rule_upd = upe_pkg::RULE_ANY;
    end else if (byte_in >= 8'he0 && byte_in <= 8'hef) begin
      pend_upd = 2'd2;
      rule_upd = (byte_in == 8'he0) ? upe_pkg::RULE_A0_BF :
                 (byte_in == 8'hed) ? upe_pkg::RULE_80_9F : upe_pkg::RULE_ANY;
    end else if (byte_in >= 8'hf0 && byte_in <= 8'hf4) begin
      pend_upd = 2'd3;
      rule_upd = (byte_in == 8'hf0) ? upe_pkg::RULE_90_BF :
                 (byte_in == 8'hf4) ? upe_pkg::RULE_80_8F : upe_pkg::RULE_ANY;
    end else if (byte_in >= 8'h80) begin
      fail_upd = 1'b1;
    end
    // Truncated sequence at the end of the string
    if (last_in && pend_upd != 2'd0) begin
      fail_upd = 1'b1;
    end
  end

  assign bad = fail_upd;

  // Drop all state at the end of a string
  always_comb begin
    pend_nxt = pend_r;
    rule_nxt = rule_r;
    fail_nxt = fail_r;
    if (accept) begin
      pend_nxt = last_in ? 2'd0 : pend_upd;
      rule_nxt = last_in ? upe_pkg::RULE_ANY : rule_upd;
      fail_nxt = last_in ? 1'b0 : fail_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
      rule_r <= upe_pkg::RULE_ANY;
      fail_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      rule_r <= rule_nxt;
      fail_r <= fail_nxt;
    end
  end

  // A rule only survives while a continuation is expected
  a_rule_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r == 2'd0) |-> (rule_r == upe_pkg::RULE_ANY))
    else $error("second byte rule set with nothing pending");

  // Restricted rules come only from three- and four-byte leads
  a_rule_long_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (rule_r != upe_pkg::RULE_ANY) |-> (pend_r == 2'd2 || pend_r == 2'd3))
    else $error("second byte rule with short sequence");

  // A finished string leaves clean state
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last_in) |=> (pend_r == 2'd0 && !fail_r))
    else $error("state not cleared after end of string");

endmodule

// File: rtl/upe_emitter.sv
// Result register and beat counter: holds one encoded request and sends its
// one or three characters out. Depends on upe_pkg.
module upe_emitter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  upe_pkg::enc_rec_t rec_in,
  output logic              take_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_char,
  output logic              out_run_last,
  output logic              out_string_end,
  output logic              out_bad_utf8
);

  upe_pkg::enc_rec_t rec_r, rec_nxt;
  logic              valid_r, valid_nxt;
  logic [1:0]        beat_r, beat_nxt;
  logic              final_beat;
  logic              fire;

  assign final_beat = !rec_r.escaped || (beat_r == 2'd2);
  assign fire       = valid_r && out_ready;
  assign take_ready = !valid_r || (out_ready && final_beat);

  // Select the character of the current beat
  always_comb begin
    case (beat_r)
      2'd0:    out_char = rec_r.char0;
      2'd1:    out_char = rec_r.char1;
      default: out_char = rec_r.char2;
    endcase
  end

  assign out_valid      = valid_r;
  assign out_run_last   = final_beat;
  assign out_string_end = final_beat && rec_r.last;
  assign out_bad_utf8   = rec_r.bad;

  // Advance the beat, or load the next request after the final one
  always_comb begin
    rec_nxt   = rec_r;
    valid_nxt = valid_r;
    beat_nxt  = beat_r;
    if (fire) begin
      if (final_beat) begin
        beat_nxt  = 2'd0;
        valid_nxt = 1'b0;
      end else begin
        beat_nxt = beat_r + 2'd1;
      end
    end
    if (load) begin
      rec_nxt   = rec_in;
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      beat_r  <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      beat_r  <= beat_nxt;
    end
  end

  a_beat_range: assert property (@(posedge clk) disable iff (!rst_n)
    beat_r != 2'd3)
    else $error("beat counter out of range");

  a_idle_beat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r |-> (beat_r == 2'd0))
    else $error("beat counter not at zero while empty");

  a_plain_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !rec_r.escaped) |-> (beat_r == 2'd0))
    else $error("pass-through request past first beat");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> take_ready)
    else $error("request loaded over a pending one");

endmodule

// File: rtl/uri_percent_encoder.sv
// URI percent encoder top level: configuration register, character
// classification and escape formation. Depends on upe_pkg, upe_utf8_track
// and upe_emitter.
//
// Usage:
//   in_*  : one byte of a UTF-8 string per request (in_byte, in_last marks
//           the final byte). Valid/ready handshake.
//   out_* : one ASCII character per request. A byte the selected table allows
//           gives one character; any other byte gives '%' and two lowercase
//           hex digits. out_run_last marks the last character of a byte,
//           out_string_end the last character of the string, out_bad_utf8 a
//           strict UTF-8 fault so far in the string (discard it).
//   cfg_* : cfg_table_select, 0 = URI component set, 1 = full URI set.
//           Always ready; write it only while the block is idle.
// The first character of a byte is offered in the cycle after it is taken.
// Throughput is bounded by the one-character-per-cycle result port while the
// receiver is ready: one character for a passed byte, three for an escaped
// byte. The next byte is taken in the same cycle as the last character of
// the current one. Reset clears the UTF-8 state, the table select and the
// result valid flag and beat counter. A stalled receiver holds the current
// character; input is held off after one byte waits in the result register.
module uri_percent_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_run_last,
  output logic       out_string_end,
  output logic       out_bad_utf8,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_table_select
);

  logic              table_sel_r, table_sel_nxt;
  logic              accept;
  logic              bad;
  logic              allowed;
  upe_pkg::enc_rec_t rec;

  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Hold the table select until the next write request
  assign table_sel_nxt = (cfg_valid && cfg_ready) ? cfg_table_select : table_sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_sel_r <= 1'b0;
    end else begin
      table_sel_r <= table_sel_nxt;
    end
  end

  upe_utf8_track u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .byte_in (in_byte),
    .last_in (in_last),
    .bad     (bad)
  );

  // Classify the byte and form the escape
  always_comb begin
    allowed = (in_byte >= upe_pkg::PRINT_LO) && (in_byte <= upe_pkg::PRINT_HI) &&
              (table_sel_r ? upe_pkg::full_allowed(in_byte)
                           : upe_pkg::comp_allowed(in_byte));
    rec.escaped = !allowed;
    rec.char0   = allowed ? in_byte : upe_pkg::CHAR_PERCENT;
    rec.char1   = upe_pkg::hex_digit(in_byte[7:4]);
    rec.char2   = upe_pkg::hex_digit(in_byte[3:0]);
    rec.last    = in_last;
    rec.bad     = bad;
  end

  upe_emitter u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (accept),
    .rec_in         (rec),
    .take_ready     (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end),
    .out_bad_utf8   (out_bad_utf8)
  );

endmodule

// File: sim/tb_uri_percent_encoder.sv
// Testbench for uri_percent_encoder: a directed table, then random UTF-8 strings,
// checked against a typed-in run or an in-bench strict UTF-8 percent encoder.
// Depends on rtl/upe_pkg.sv and rtl/uri_percent_encoder.sv.
module tb_uri_percent_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int RANDOM_PER_PHASE = 30;

  // One output character as the block should present it
  typedef struct packed {
    logic [7:0] ch;
    logic       run_last;
    logic       str_end;
    logic       bad;
  } enc_char_t;

  // All characters one input byte turns into
  typedef struct packed {
    logic [1:0] n;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic       bad;
  } enc_run_t;

  // Directed row: table select, request, and the typed-in run where it is obvious
  typedef struct packed {
    logic       sel;
    logic [7:0] b;
    logic       last;
    logic       typed;
    enc_run_t   run;
  } dir_row_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h41;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char;
  logic       out_run_last;
  logic       out_string_end;
  logic       out_bad_utf8;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_table_select = 1'b0;

  // Encoder state mirrored in the bench
  logic [1:0]     cont_left = 2'd0;
  upe_pkg::rule_t cont_rule = upe_pkg::RULE_ANY;
  logic           string_bad = 1'b0;
  logic           table_full = 1'b0;

  enc_char_t  pending_chars[$];
  logic [7:0] str_bytes[$];
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         errors = 0;
  int         cycle_count = 0;

  dir_row_t dir_rows [27] = '{
    '{1'b0, 8'h41, 1'b0, 1'b1, '{2'd1, "A", 8'h00, 8'h00, 1'b0}},
    '{1'b0, 8'h7e, 1'b0, 1'b1, '{2'd1, "~", 8'h00, 8'h00, 1'b0}},
    '{1'b0, 8'h01, 1'b0, 1'b1, '{2'd3, "%", "0", "1", 1'b0}},
    '{1'b0, 8'h20, 1'b0, 1'b1, '{2'd3, "%", "2", "0", 1'b0}},
    '{1'b0, 8'h7f, 1'b0, 1'b1, '{2'd3, "%", "7", "f", 1'b0}},
    '{1'b0, 8'h2f, 1'b1, 1'b1, '{2'd3, "%", "2", "f", 1'b0}},
    // three-byte sequence, E0 needs A0..BF next
    '{1'b0, 8'he0, 1'b0, 1'b0, '0},
    '{1'b0, 8'ha0, 1'b0, 1'b0, '0},
    '{1'b0, 8'h80, 1'b1, 1'b0, '0},
    // ED followed by A0 is a surrogate: bad continuation
    '{1'b0, 8'hed, 1'b0, 1'b0, '0},
    '{1'b0, 8'ha0, 1'b1, 1'b0, '0},
    // F4 followed by 90 is above U+10FFFF
    '{1'b0, 8'hf4, 1'b0, 1'b0, '0},
    '{1'b0, 8'h90, 1'b1, 1'b0, '0},
    // bad lead byte, then the flag sticks on a plain character
    '{1'b0, 8'hff, 1'b0, 1'b1, '{2'd3, "%", "f", "f", 1'b1}},
    '{1'b0, 8'h41, 1'b1, 1'b1, '{2'd1, "A", 8'h00, 8'h00, 1'b1}},
    // string cut short inside a sequence
    '{1'b0, 8'he2, 1'b0, 1'b0, '0},
    '{1'b0, 8'h82, 1'b1, 1'b0, '0},
    // ASCII where a continuation is due
    '{1'b0, 8'hc3, 1'b0, 1'b0, '0},
    '{1'b0, 8'h3a, 1'b1, 1'b0, '0},
    // full URI table lets reserved characters through
    '{1'b1, 8'h3b, 1'b0, 1'b0, '0},
    '{1'b1, 8'h23, 1'b0, 1'b0, '0},
    '{1'b1, 8'h25, 1'b0, 1'b1, '{2'd3, "%", "2", "5", 1'b0}},
    '{1'b1, 8'hf0, 1'b0, 1'b0, '0},
    '{1'b1, 8'h90, 1'b0, 1'b0, '0},
    '{1'b1, 8'h80, 1'b0, 1'b0, '0},
    '{1'b1, 8'hbf, 1'b1, 1'b0, '0},
    '{1'b1, 8'hc1, 1'b1, 1'b1, '{2'd3, "%", "c", "1", 1'b1}}
  };

  uri_percent_encoder i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_char         (out_char),
    .out_run_last     (out_run_last),
    .out_string_end   (out_string_end),
    .out_bad_utf8     (out_bad_utf8),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_table_select (cfg_table_select)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Lowercase hex digit of a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h61 + 8'(nib) - 8'd10;
  endfunction

  // Track strict UTF-8 for one byte and work out the characters it becomes
  function automatic enc_run_t encode_byte(input logic [7:0] b, input logic last);
    enc_run_t r;
    logic     cont_ok;
    logic     plain;
    r = '0;
    if (cont_left != 2'd0) begin
      cont_ok = (b >= 8'h80) && (b <= 8'hbf);
      case (cont_rule)
        upe_pkg::RULE_A0_BF: if (b < 8'ha0) cont_ok = 1'b0;
        upe_pkg::RULE_80_9F: if (b > 8'h9f) cont_ok = 1'b0;
        upe_pkg::RULE_90_BF: if (b < 8'h90) cont_ok = 1'b0;
        upe_pkg::RULE_80_8F: if (b > 8'h8f) cont_ok = 1'b0;
        default: ;
      endcase
      // a failed continuation is not read again as a lead byte
      if (cont_ok) begin
        cont_left = cont_left - 2'd1;
      end else begin
        string_bad = 1'b1;
        cont_left = 2'd0;
      end
      cont_rule = upe_pkg::RULE_ANY;
    end else if (b >= 8'hc2 && b <= 8'hdf) begin
      cont_left = 2'd1;
      cont_rule = upe_pkg::RULE_ANY;
    end else if (b >= 8'he0 && b <= 8'hef) begin
      cont_left = 2'd2;
      cont_rule = (b == 8'he0) ? upe_pkg::RULE_A0_BF :
                  (b == 8'hed) ? upe_pkg::RULE_80_9F : upe_pkg::RULE_ANY;
    end else if (b >= 8'hf0 && b <= 8'hf4) begin
      cont_left = 2'd3;
      cont_rule = (b == 8'hf0) ? upe_pkg::RULE_90_BF :
                  (b == 8'hf4) ? upe_pkg::RULE_80_8F : upe_pkg::RULE_ANY;
    end else if (b >= 8'h80) begin
      string_bad = 1'b1;
    end
    // truncated sequence at the end of the string
    if (last && cont_left != 2'd0) string_bad = 1'b1;
    r.bad = string_bad;

    // classify against the selected table
    plain = (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    case (b)
      "-", "_", ".", "!", "~", "*", "'", "(", ")": plain = 1'b1;
      ";", ",", "/", "?", ":", "@", "&", "=", "+", "$", "#": if (table_full) plain = 1'b1;
      default: ;
    endcase
    if (plain) begin
      r.n = 2'd1;
      r.c0 = b;
    end else begin
      r.n = 2'd3;
      r.c0 = "%";
      r.c1 = hex_char(b[7:4]);
      r.c2 = hex_char(b[3:0]);
    end

    // start the next string clean
    if (last) begin
      cont_left = 2'd0;
      cont_rule = upe_pkg::RULE_ANY;
      string_bad = 1'b0;
    end
    return r;
  endfunction

  // Append the characters of one byte to the expected stream
  task automatic queue_run(input enc_run_t r, input logic last);
    logic [7:0] chars [3];
    chars = '{r.c0, r.c1, r.c2};
    for (int k = 0; k < r.n; k++) begin
      pending_chars.push_back('{chars[k], k == r.n - 1, last && (k == r.n - 1), r.bad});
    end
  endtask

  // Offer one request, wait for it to be taken, then predict its characters
  task automatic send_req(input logic [7:0] b, input logic last,
                          input logic typed, input enc_run_t typed_run);
    enc_run_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    do @(posedge clk); while (!in_ready);
    r = encode_byte(b, last);
    queue_run(typed ? typed_run : r, last);
  endtask

  // Drain the block, then write the table select
  task automatic write_table(input logic sel);
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid        <= 1'b1;
    cfg_table_select <= sel;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    table_full = sel;
  endtask

  // Append one character: ASCII, control, or a well-formed multibyte sequence
  task automatic add_char();
    logic [7:0] lead;
    logic [7:0] lo;
    logic [7:0] hi;
    int         kind;
    kind = $urandom_range(9);
    lo = 8'h80;
    hi = 8'hbf;
    if (kind < 4) begin
      str_bytes.push_back(8'($urandom_range(126, 32)));
    end else if (kind == 4) begin
      lead = 8'($urandom_range(32, 1));
      str_bytes.push_back((lead == 8'd32) ? 8'h7f : lead);
    end else if (kind < 7) begin
      str_bytes.push_back(8'($urandom_range(8'hdf, 8'hc2)));
      str_bytes.push_back(8'($urandom_range(hi, lo)));
    end else if (kind < 9) begin
      case ($urandom_range(3))
        0: lead = 8'he0;
        1: lead = 8'hed;
        default: lead = 8'($urandom_range(8'hef, 8'he0));
      endcase
      if (lead == 8'he0) lo = 8'ha0;
      if (lead == 8'hed) hi = 8'h9f;
      str_bytes.push_back(lead);
      str_bytes.push_back(8'($urandom_range(hi, lo)));
      str_bytes.push_back(8'($urandom_range(8'hbf, 8'h80)));
    end else begin
      case ($urandom_range(3))
        0: lead = 8'hf0;
        1: lead = 8'hf4;
        default: lead = 8'($urandom_range(8'hf4, 8'hf0));
      endcase
      if (lead == 8'hf0) lo = 8'h90;
      if (lead == 8'hf4) hi = 8'h8f;
      str_bytes.push_back(lead);
      str_bytes.push_back(8'($urandom_range(hi, lo)));
      repeat (2) str_bytes.push_back(8'($urandom_range(8'hbf, 8'h80)));
    end
  endtask

  // Build a string: mostly well-formed, some corrupted, cut short or pure noise
  task automatic add_string();
    int pos;
    str_bytes.delete();
    repeat ($urandom_range(6, 1)) add_char();
    case ($urandom_range(9))
      0: begin
        pos = $urandom_range(str_bytes.size() - 1);
        str_bytes[pos] = 8'($urandom_range(255, 1));
      end
      1: if (str_bytes.size() > 1) void'(str_bytes.pop_back());
      2: begin
        str_bytes.delete();
        repeat ($urandom_range(6, 1)) str_bytes.push_back(8'($urandom_range(255, 1)));
      end
      default: ;
    endcase
  endtask

  // Check each taken character, then pick the next ready
  always @(posedge clk) begin
    enc_char_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        errors++;
        $error("out_char: expected none, got %h", out_char);
      end else begin
        want = pending_chars.pop_front();
        if (out_char !== want.ch) begin
          errors++;
          $error("out_char: expected %h, got %h", want.ch, out_char);
        end
        if (out_run_last !== want.run_last) begin
          errors++;
          $error("out_run_last: expected %b, got %b", want.run_last, out_run_last);
        end
        if (out_string_end !== want.str_end) begin
          errors++;
          $error("out_string_end: expected %b, got %b", want.str_end, out_string_end);
        end
        if (out_bad_utf8 !== want.bad) begin
          errors++;
          $error("out_bad_utf8: expected %b, got %b", want.bad, out_bad_utf8);
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int sent;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows
    send_idle_pct = 20;
    recv_idle_pct = 88;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].sel != table_full) write_table(dir_rows[i].sel);
      send_req(dir_rows[i].b, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].run);
    end

    // random strings: receiver-heavy idling, sender-heavy idling, then none
    for (int ph = 0; ph < 6; ph++) begin
      write_table(ph[0]);
      send_idle_pct = (ph < 2) ? 20 : (ph < 4) ? 88 : 0;
      recv_idle_pct = (ph < 2) ? 88 : (ph < 4) ? 20 : 0;
      sent = 0;
      while (sent < RANDOM_PER_PHASE) begin
        add_string();
        foreach (str_bytes[i]) send_req(str_bytes[i], i == str_bytes.size() - 1, 1'b0, '0);
        sent += str_bytes.size();
      end
    end

    // drain and let any stray characters show
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
